// ----- design/gzip_member_deframer_core_assert.svh -----
// ----------------------------------------------------------------------------
// gzip member deframer assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef GZIP_MEMBER_DEFRAMER_CORE_ASSERT_SVH
`define GZIP_MEMBER_DEFRAMER_CORE_ASSERT_SVH

// condition holds at every edge
`define GMD_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define GMD_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/gmd_pkg.sv -----
// ----------------------------------------------------------------------------
// gmd_pkg
// types, constants and helpers shared by the gzip member deframer
// ----------------------------------------------------------------------------
package gmd_pkg;

	localparam logic [7:0] MAGIC_A        = 8'h1F;
	localparam logic [7:0] MAGIC_B        = 8'h8B;
	localparam logic [7:0] METHOD_DEFLATE = 8'h08;

	// header flag byte positions
	localparam int FL_HCRC_BIT    = 1;
	localparam int FL_EXTRA_BIT   = 2;
	localparam int FL_NAME_BIT    = 3;
	localparam int FL_COMMENT_BIT = 4;

	// positions in the stored flag vector
	localparam int FB_HCRC    = 0;
	localparam int FB_EXTRA   = 1;
	localparam int FB_NAME    = 2;
	localparam int FB_COMMENT = 3;

	localparam logic [4:0]  MIN_MEMBER    = 5'd18;
	localparam int          TRAILER_DEPTH = 8;
	localparam logic [3:0]  TRAILER_FULL  = 4'd8;
	localparam logic [15:0] FIXED_LEN     = 16'd6;
	localparam logic [15:0] HCRC_LEN      = 16'd2;

	localparam int FIFO_DEPTH = 4;
	localparam int TDATA_W    = 80;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
	localparam logic [2:0] ST_TRUNC     = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	// where to resume the search for the next enabled header section
	localparam logic [1:0] ENTER_EXTRA   = 2'd0;
	localparam logic [1:0] ENTER_NAME    = 2'd1;
	localparam logic [1:0] ENTER_COMMENT = 2'd2;
	localparam logic [1:0] ENTER_HCRC    = 2'd3;

	typedef enum logic [12:0] {
		PH_MAGIC_A = 13'b0_0000_0000_0001,
		PH_MAGIC_B = 13'b0_0000_0000_0010,
		PH_METHOD  = 13'b0_0000_0000_0100,
		PH_FLAGS   = 13'b0_0000_0000_1000,
		PH_FIXED   = 13'b0_0000_0001_0000,
		PH_XLEN_LO = 13'b0_0000_0010_0000,
		PH_XLEN_HI = 13'b0_0000_0100_0000,
		PH_XDATA   = 13'b0_0000_1000_0000,
		PH_NAME    = 13'b0_0001_0000_0000,
		PH_COMMENT = 13'b0_0010_0000_0000,
		PH_HCRC    = 13'b0_0100_0000_0000,
		PH_PAYLOAD = 13'b0_1000_0000_0000,
		PH_DEAD    = 13'b1_0000_0000_0000
	} phase_t;

	typedef struct packed {
		logic [31:0] trailer_size;
		logic [31:0] trailer_crc;
		logic [2:0]  status;
		logic        is_report;
		logic [7:0]  out_byte;
	} result_t;

	function automatic phase_t enter_from(input logic [1:0] lvl, input logic [3:0] fl);
		phase_t ph;
		if (lvl <= ENTER_EXTRA && fl[FB_EXTRA]) begin
			ph = PH_XLEN_LO;
		end else if (lvl <= ENTER_NAME && fl[FB_NAME]) begin
			ph = PH_NAME;
		end else if (lvl <= ENTER_COMMENT && fl[FB_COMMENT]) begin
			ph = PH_COMMENT;
		end else if (fl[FB_HCRC]) begin
			ph = PH_HCRC;
		end else begin
			ph = PH_PAYLOAD;
		end
		return ph;
	endfunction

endpackage

// ----- design/gmd_parser.sv -----
// ----------------------------------------------------------------------------
// gmd_parser
// header walk, trailer delay line and end-of-member status for one byte
// ----------------------------------------------------------------------------
module gmd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        data_byte,
	input  logic              final_byte,
	output logic              pay_valid,
	output gmd_pkg::result_t  pay_res,
	output logic              rep_valid,
	output gmd_pkg::result_t  rep_res
);
	import gmd_pkg::*;

	phase_t      phase_q, phase_n;
	logic [15:0] skip_q, skip_n, skip_dec, xlen;
	logic [3:0]  flags_q, flags_n;
	logic [3:0]  fill_q, fill_n;
	logic [4:0]  total_q, total_n;
	logic        bad_q, bad_n;
	logic        seen_q, seen_n;
	logic [7:0]  line_q [TRAILER_DEPTH];
	logic [7:0]  line_n [TRAILER_DEPTH];
	logic        enter;
	logic [1:0]  enter_lvl;
	logic [2:0]  st;

	always_comb begin
		phase_n   = phase_q;
		skip_n    = skip_q;
		flags_n   = flags_q;
		fill_n    = fill_q;
		seen_n    = seen_q;
		bad_n     = bad_q;
		line_n    = line_q;
		enter     = 1'b0;
		enter_lvl = ENTER_EXTRA;
		pay_valid = 1'b0;
		skip_dec  = skip_q - 16'd1;
		xlen      = {data_byte, skip_q[7:0]};
		total_n   = (total_q < MIN_MEMBER) ? total_q + 5'd1 : total_q;

		if (phase_q == PH_PAYLOAD) begin
			if (fill_q < TRAILER_FULL) begin
				line_n[fill_q[2:0]] = data_byte;
				fill_n = fill_q + 4'd1;
			end else begin
				pay_valid = 1'b1;
				for (int i = 0; i < TRAILER_DEPTH - 1; i++) begin
					line_n[i] = line_q[i+1];
				end
				line_n[TRAILER_DEPTH-1] = data_byte;
				seen_n = 1'b1;
			end
		end else begin
			case (phase_q)
				PH_MAGIC_A: begin
					if (data_byte == MAGIC_A) phase_n = PH_MAGIC_B;
					else begin bad_n = 1'b1; phase_n = PH_DEAD; end
				end
				PH_MAGIC_B: begin
					if (data_byte == MAGIC_B) phase_n = PH_METHOD;
					else begin bad_n = 1'b1; phase_n = PH_DEAD; end
				end
				PH_METHOD: begin
					if (data_byte == METHOD_DEFLATE) phase_n = PH_FLAGS;
					else begin bad_n = 1'b1; phase_n = PH_DEAD; end
				end
				PH_FLAGS: begin
					flags_n = {data_byte[FL_COMMENT_BIT], data_byte[FL_NAME_BIT],
						data_byte[FL_EXTRA_BIT], data_byte[FL_HCRC_BIT]};
					skip_n  = FIXED_LEN;
					phase_n = PH_FIXED;
				end
				PH_FIXED: begin
					skip_n    = skip_dec;
					enter     = (skip_dec == 16'd0);
					enter_lvl = ENTER_EXTRA;
				end
				PH_XLEN_LO: begin
					skip_n  = {8'd0, data_byte};
					phase_n = PH_XLEN_HI;
				end
				PH_XLEN_HI: begin
					skip_n    = xlen;
					enter     = (xlen == 16'd0);
					enter_lvl = ENTER_NAME;
					if (xlen != 16'd0) phase_n = PH_XDATA;
				end
				PH_XDATA: begin
					skip_n    = skip_dec;
					enter     = (skip_dec == 16'd0);
					enter_lvl = ENTER_NAME;
				end
				PH_NAME: begin
					enter     = (data_byte == 8'd0);
					enter_lvl = ENTER_COMMENT;
				end
				PH_COMMENT: begin
					enter     = (data_byte == 8'd0);
					enter_lvl = ENTER_HCRC;
				end
				PH_HCRC: begin
					skip_n = skip_dec;
					if (skip_dec == 16'd0) phase_n = PH_PAYLOAD;
				end
				default: begin
				end
			endcase
			if (enter) begin
				phase_n = enter_from(enter_lvl, flags_q);
				if (phase_n == PH_HCRC) skip_n = HCRC_LEN;
			end
		end

		// status priority on the final byte
		if (total_n < MIN_MEMBER) st = ST_SHORT;
		else if (bad_n) st = ST_BAD_MAGIC;
		else if (phase_n != PH_PAYLOAD || fill_n < TRAILER_FULL) st = ST_TRUNC;
		else if (!seen_n) st = ST_EMPTY;
		else st = ST_OK;

		pay_res              = '0;
		pay_res.out_byte     = line_q[0];
		rep_valid            = final_byte;
		rep_res              = '0;
		rep_res.is_report    = 1'b1;
		rep_res.status       = st;
		if (st == ST_OK || st == ST_EMPTY) begin
			rep_res.trailer_crc  = {line_n[3], line_n[2], line_n[1], line_n[0]};
			rep_res.trailer_size = {line_n[7], line_n[6], line_n[5], line_n[4]};
		end

		// member done, next byte starts a new one
		if (final_byte) begin
			phase_n = PH_MAGIC_A;
			skip_n  = '0;
			flags_n = '0;
			fill_n  = '0;
			total_n = '0;
			bad_n   = 1'b0;
			seen_n  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC_A;
			skip_q  <= '0;
			flags_q <= '0;
			fill_q  <= '0;
			total_q <= '0;
			bad_q   <= 1'b0;
			seen_q  <= 1'b0;
		end else if (fire) begin
			phase_q <= phase_n;
			skip_q  <= skip_n;
			flags_q <= flags_n;
			fill_q  <= fill_n;
			total_q <= total_n;
			bad_q   <= bad_n;
			seen_q  <= seen_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			line_q <= line_n;
		end
	end

endmodule

// ----- design/gmd_out_fifo.sv -----
// ----------------------------------------------------------------------------
// gmd_out_fifo
// result queue taking up to two results per cycle and giving one while out_ready is high
// ----------------------------------------------------------------------------
module gmd_out_fifo #(
	parameter int DEPTH = gmd_pkg::FIFO_DEPTH,
	parameter int LVL_W = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_a,
	input  gmd_pkg::result_t  din_a,
	input  logic              push_b,
	input  gmd_pkg::result_t  din_b,
	output logic              room2,
	output logic [LVL_W-1:0]  level,
	output logic              out_valid,
	input  logic              out_ready,
	output gmd_pkg::result_t  dout
);
	import gmd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	result_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q, wr_ptr_b, wr_next;
	logic [LVL_W-1:0]   level_q, n_push;
	logic               pop;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	assign pop       = out_valid && out_ready;
	assign n_push    = LVL_W'(push_a) + LVL_W'(push_b);
	assign wr_ptr_b  = push_a ? ptr_inc(wr_ptr_q) : wr_ptr_q;
	assign wr_next   = push_b ? ptr_inc(wr_ptr_b) : wr_ptr_b;
	assign out_valid = (level_q != '0);
	assign dout      = mem_q[rd_ptr_q];
	assign level     = level_q;
	assign room2     = (level_q <= LVL_W'(DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_next;
			if (pop) rd_ptr_q <= ptr_inc(rd_ptr_q);
			level_q <= level_q + n_push - LVL_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_a) mem_q[wr_ptr_q] <= din_a;
		if (push_b) mem_q[wr_ptr_b] <= din_b;
	end

endmodule

// ----- design/gzip_member_deframer_core.sv -----
// a byte transfer is registered, then parsed into the result queue once that queue has
// room for two results; throughput: one byte per cycle while the queue has that room;
// the final byte may add a second result (the report), drained one per cycle while
// m_axis_tready is high from a four-entry queue that holds back input when nearly full
// reset: arst_n clears the header walk, counters and queue; the delay line is not cleared
// ----------------------------------------------------------------------------
// gzip_member_deframer_core
// gzip member header/trailer deframer with payload passthrough and status report
// ----------------------------------------------------------------------------
`include "gzip_member_deframer_core_assert.svh"

module gzip_member_deframer_core #(
	parameter int FIFO_DEPTH = gmd_pkg::FIFO_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
	input  logic                        s_axis_tlast,   // final_byte
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// [7:0] out_byte, [10:8] status, [42:11] trailer_crc, [74:43] trailer_size, rest zero
	output logic [gmd_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic                        m_axis_tlast    // is_report
);
	import gmd_pkg::*;

	localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

	logic             in_valid_s1;
	logic [7:0]       in_byte_s1;
	logic             in_last_s1;
	logic             proc_fire;
	logic             pay_valid, rep_valid, room2;
	result_t          pay_res, rep_res, q_out;
	logic [LVL_W-1:0] q_level;

	assign proc_fire     = in_valid_s1 && room2;
	assign s_axis_tready = !in_valid_s1 || proc_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			in_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			in_byte_s1 <= s_axis_tdata;
			in_last_s1 <= s_axis_tlast;
		end
	end

	gmd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (proc_fire),
		.data_byte  (in_byte_s1),
		.final_byte (in_last_s1),
		.pay_valid  (pay_valid),
		.pay_res    (pay_res),
		.rep_valid  (rep_valid),
		.rep_res    (rep_res)
	);

	gmd_out_fifo #(
		.DEPTH (FIFO_DEPTH),
		.LVL_W (LVL_W)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_a    (proc_fire && pay_valid),
		.din_a     (pay_res),
		.push_b    (proc_fire && rep_valid),
		.din_b     (rep_res),
		.room2     (room2),
		.level     (q_level),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.dout      (q_out)
	);

	assign m_axis_tdata = {(TDATA_W - 75)'(0), q_out.trailer_size, q_out.trailer_crc,
		q_out.status, q_out.out_byte};
	assign m_axis_tlast = q_out.is_report;

	`GMD_ASSERT_ALWAYS(a_level_bound, q_level <= LVL_W'(FIFO_DEPTH), "result queue overflow")
	`GMD_ASSERT_IMPL(a_report_no_byte, m_axis_tvalid && m_axis_tlast, m_axis_tdata[7:0] == 8'd0, "report carries a payload byte")
	`GMD_ASSERT_IMPL(a_payload_clean, m_axis_tvalid && !m_axis_tlast, m_axis_tdata[TDATA_W-1:8] == '0, "payload transfer carries status or trailer")
	`GMD_ASSERT_NEXT(a_s1_hold, in_valid_s1 && !proc_fire, in_valid_s1, "held input byte lost")

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// gzip member deframer bench: byte members over the slave stream, payload and
// end-of-member reports checked on the master stream against a local model
// ----------------------------------------------------------------------------
module tb;
	import gmd_pkg::*;

	localparam int unsigned ITEM_GOAL   = 1950;
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned DRAIN_TICKS = 16;

	typedef struct packed {
		logic [7:0] data;
		logic       fin;
		logic       hold;
	} gz_byte_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        rpt;
		logic [2:0]  status;
		logic [31:0] crc;
		logic [31:0] size;
	} deframed_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [7:0]          s_axis_tdata = 8'd0;   // [7:0] data_byte
	logic                s_axis_tlast = 1'b0;   // final_byte
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [TDATA_W-1:0]  m_axis_tdata;          // [7:0] out_byte, [10:8] status,
	                                            // [42:11] trailer_crc, [74:43] trailer_size
	logic                m_axis_tlast;          // is_report

	gz_byte_t    byte_plan[$];
	logic [7:0]  member_buf[$];
	deframed_t   expected[$];
	deframed_t   head;

	int unsigned item_total = 0;
	int unsigned accepted = 0;
	int unsigned quiet_ticks = 0;
	int unsigned errors = 0;
	int unsigned members_done = 0;
	int unsigned payload_out = 0;
	int unsigned status_seen[5];

	// model state
	phase_t      hdr_phase;
	logic [15:0] skip_cnt;
	logic [3:0]  hdr_flags;
	logic [7:0]  trail[TRAILER_DEPTH];
	int unsigned trail_fill;
	int unsigned seen_total;
	logic [2:0]  err_code;
	logic        got_payload;

	gzip_member_deframer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// member model
	// ------------------------------------------------------------------
	task automatic clear_member();
		hdr_phase   = PH_MAGIC_A;
		skip_cnt    = 16'd0;
		hdr_flags   = 4'd0;
		trail_fill  = 0;
		seen_total  = 0;
		err_code    = ST_OK;
		got_payload = 1'b0;
	endtask

	// first enabled section at or after the given one
	task automatic next_section(input phase_t from);
		if (from <= PH_XLEN_LO && hdr_flags[FB_EXTRA]) begin
			hdr_phase = PH_XLEN_LO;
		end else if (from <= PH_NAME && hdr_flags[FB_NAME]) begin
			hdr_phase = PH_NAME;
		end else if (from <= PH_COMMENT && hdr_flags[FB_COMMENT]) begin
			hdr_phase = PH_COMMENT;
		end else if (hdr_flags[FB_HCRC]) begin
			hdr_phase = PH_HCRC;
			skip_cnt  = HCRC_LEN;
		end else begin
			hdr_phase = PH_PAYLOAD;
		end
	endtask

	task automatic walk_header(input logic [7:0] b);
		case (hdr_phase)
			PH_MAGIC_A: begin
				if (b == MAGIC_A) hdr_phase = PH_MAGIC_B;
				else begin err_code = ST_BAD_MAGIC; hdr_phase = PH_DEAD; end
			end
			PH_MAGIC_B: begin
				if (b == MAGIC_B) hdr_phase = PH_METHOD;
				else begin err_code = ST_BAD_MAGIC; hdr_phase = PH_DEAD; end
			end
			PH_METHOD: begin
				if (b == METHOD_DEFLATE) hdr_phase = PH_FLAGS;
				else begin err_code = ST_BAD_MAGIC; hdr_phase = PH_DEAD; end
			end
			PH_FLAGS: begin
				hdr_flags[FB_HCRC]    = b[FL_HCRC_BIT];
				hdr_flags[FB_EXTRA]   = b[FL_EXTRA_BIT];
				hdr_flags[FB_NAME]    = b[FL_NAME_BIT];
				hdr_flags[FB_COMMENT] = b[FL_COMMENT_BIT];
				skip_cnt  = FIXED_LEN;
				hdr_phase = PH_FIXED;
			end
			PH_FIXED: begin
				skip_cnt = skip_cnt - 16'd1;
				if (skip_cnt == 16'd0) next_section(PH_XLEN_LO);
			end
			PH_XLEN_LO: begin
				skip_cnt  = {8'd0, b};
				hdr_phase = PH_XLEN_HI;
			end
			PH_XLEN_HI: begin
				skip_cnt = {b, skip_cnt[7:0]};
				if (skip_cnt == 16'd0) next_section(PH_NAME);
				else hdr_phase = PH_XDATA;
			end
			PH_XDATA: begin
				skip_cnt = skip_cnt - 16'd1;
				if (skip_cnt == 16'd0) next_section(PH_NAME);
			end
			PH_NAME: begin
				if (b == 8'd0) next_section(PH_COMMENT);
			end
			PH_COMMENT: begin
				if (b == 8'd0) next_section(PH_HCRC);
			end
			PH_HCRC: begin
				skip_cnt = skip_cnt - 16'd1;
				if (skip_cnt == 16'd0) hdr_phase = PH_PAYLOAD;
			end
			default: begin
			end
		endcase
	endtask

	task automatic deframe_byte(input logic [7:0] b, input logic fin);
		deframed_t r;
		logic [2:0] st;
		if (seen_total < MIN_MEMBER) seen_total++;
		if (hdr_phase == PH_PAYLOAD) begin
			if (trail_fill < TRAILER_DEPTH) begin
				trail[trail_fill] = b;
				trail_fill++;
			end else begin
				r = '0;
				r.out_byte = trail[0];
				expected.push_back(r);
				for (int i = 0; i < TRAILER_DEPTH - 1; i++) trail[i] = trail[i+1];
				trail[TRAILER_DEPTH-1] = b;
				got_payload = 1'b1;
				payload_out++;
			end
		end else begin
			walk_header(b);
		end
		if (fin) begin
			if (seen_total < MIN_MEMBER) st = ST_SHORT;
			else if (err_code == ST_BAD_MAGIC) st = ST_BAD_MAGIC;
			else if (hdr_phase != PH_PAYLOAD || trail_fill < TRAILER_DEPTH) st = ST_TRUNC;
			else if (!got_payload) st = ST_EMPTY;
			else st = ST_OK;
			r = '0;
			r.rpt = 1'b1;
			r.status = st;
			// trailer fields only mean something once the whole trailer was seen
			if (st == ST_OK || st == ST_EMPTY) begin
				r.crc  = {trail[3], trail[2], trail[1], trail[0]};
				r.size = {trail[7], trail[6], trail[5], trail[4]};
			end
			expected.push_back(r);
			status_seen[st]++;
			members_done++;
			clear_member();
		end
	endtask

	// ------------------------------------------------------------------
	// member builders
	// ------------------------------------------------------------------
	function automatic logic [7:0] rand_byte(input int unsigned lo, input int unsigned hi);
		int unsigned v;
		v = $urandom_range(lo, hi);
		return v[7:0];
	endfunction

	task automatic build_good_member();
		logic [7:0] flg;
		int unsigned n;
		int unsigned xl;
		member_buf.delete();
		flg = rand_byte(0, 255);
		member_buf.push_back(MAGIC_A);
		member_buf.push_back(MAGIC_B);
		member_buf.push_back(METHOD_DEFLATE);
		member_buf.push_back(flg);
		repeat (6) member_buf.push_back(rand_byte(0, 255));
		if (flg[FL_EXTRA_BIT]) begin
			xl = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
			member_buf.push_back(xl[7:0]);
			member_buf.push_back(xl[15:8]);
			repeat (xl) member_buf.push_back(rand_byte(0, 255));
		end
		if (flg[FL_NAME_BIT]) begin
			n = $urandom_range(0, 5);
			repeat (n) member_buf.push_back(rand_byte(1, 255));
			member_buf.push_back(8'd0);
		end
		if (flg[FL_COMMENT_BIT]) begin
			n = $urandom_range(0, 5);
			repeat (n) member_buf.push_back(rand_byte(1, 255));
			member_buf.push_back(8'd0);
		end
		if (flg[FL_HCRC_BIT]) repeat (2) member_buf.push_back(rand_byte(0, 255));
		n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
		repeat (n + TRAILER_DEPTH) member_buf.push_back(rand_byte(0, 255));
	endtask

	task automatic plan_member(input logic hold);
		gz_byte_t it;
		for (int i = 0; i < member_buf.size(); i++) begin
			it.data = member_buf[i];
			it.fin  = (i == member_buf.size() - 1);
			it.hold = hold && (i == 0);
			byte_plan.push_back(it);
		end
	endtask

	task automatic plan_bytes(input logic [7:0] bytes[$]);
		member_buf = bytes;
		plan_member(1'b0);
	endtask

	// hold the first byte of roughly every tenth member until the block has drained
	function automatic logic members_planned_hold(input int unsigned planned);
		return ($urandom_range(0, 9) == 0) || (planned < 30);
	endfunction

	// ------------------------------------------------------------------
	// idle schedule: none, sender gaps, receiver stalls, both
	// ------------------------------------------------------------------
	function automatic int unsigned idle_mode();
		int unsigned m;
		if (item_total == 0) return 0;
		m = accepted * 4 / item_total;
		return (m > 3) ? 3 : m;
	endfunction

	function automatic int unsigned src_gap_pct();
		case (idle_mode())
			1: return 52;
			3: return 32;
			default: return 0;
		endcase
	endfunction

	function automatic int unsigned sink_stall_pct();
		case (idle_mode())
			2: return 52;
			3: return 32;
			default: return 0;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// driver
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			// a held byte waits until nothing is in flight and all results are out
			if (byte_plan.size() != 0
					&& (!byte_plan[0].hold || (!s_axis_tvalid && expected.size() == 0))
					&& $urandom_range(0, 99) >= src_gap_pct()) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= byte_plan[0].data;
				s_axis_tlast  <= byte_plan[0].fin;
				void'(byte_plan.pop_front());
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) m_axis_tready <= 1'b0;
		else m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct());
	end

	// ------------------------------------------------------------------
	// monitor: predicts on input transfers, checks output transfers
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				accepted++;
				deframe_byte(s_axis_tdata, s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected transfer tdata=%h tlast=%b",
							$realtime, m_axis_tdata, m_axis_tlast);
				end else begin
					head = expected.pop_front();
					if (m_axis_tdata[7:0] !== head.out_byte || m_axis_tlast !== head.rpt
							|| m_axis_tdata[10:8] !== head.status
							|| m_axis_tdata[42:11] !== head.crc
							|| m_axis_tdata[74:43] !== head.size
							|| m_axis_tdata[TDATA_W-1:75] !== '0) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: mismatch exp byte=%h rpt=%b st=%0d crc=%h size=%h",
								$realtime, head.out_byte, head.rpt, head.status, head.crc,
								head.size);
							$display("%0t:          got byte=%h rpt=%b st=%0d crc=%h size=%h pad=%h",
								$realtime, m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[10:8],
								m_axis_tdata[42:11], m_axis_tdata[74:43],
								m_axis_tdata[TDATA_W-1:75]);
						end
					end
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_ticks = 0;
			end else begin
				quiet_ticks++;
				if (quiet_ticks >= STALL_LIMIT) begin
					$display("watchdog: no transfer for %0d cycles, %0d results pending",
						quiet_ticks, expected.size());
					$display("RESULT: ERROR");
					$finish;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		int unsigned k;
		int unsigned n;
		int unsigned pos;
		logic [7:0]  flg;

		clear_member();
		foreach (status_seen[i]) status_seen[i] = 0;

		// one byte alone: too short
		plan_bytes('{8'hFF});
		// minimal member, reserved flag bits only, no payload, extreme trailer bytes
		plan_bytes('{MAGIC_A, MAGIC_B, METHOD_DEFLATE, 8'hE0,
			8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00,
			8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00});
		// header asking for extra, name and comment, cut off early
		plan_bytes('{MAGIC_A, MAGIC_B, METHOD_DEFLATE, 8'h1C, 8'h00, 8'h00});

		while (byte_plan.size() < ITEM_GOAL) begin
			k = $urandom_range(0, 99);
			build_good_member();
			if (k < 60) begin
			end else if (k < 72) begin
				// cut anywhere inside the member
				n = $urandom_range(1, member_buf.size() - 1);
				while (member_buf.size() > n) void'(member_buf.pop_back());
			end else if (k < 82) begin
				pos = $urandom_range(0, 2);
				member_buf[pos] = member_buf[pos] ^ rand_byte(1, 255);
			end else if (k < 87) begin
				// extra field longer than what follows
				member_buf.delete();
				flg = rand_byte(0, 255) | (8'd1 << FL_EXTRA_BIT);
				member_buf.push_back(MAGIC_A);
				member_buf.push_back(MAGIC_B);
				member_buf.push_back(METHOD_DEFLATE);
				member_buf.push_back(flg);
				repeat (6) member_buf.push_back(rand_byte(0, 255));
				member_buf.push_back(rand_byte(0, 255));
				member_buf.push_back(rand_byte(1, 255));
				repeat ($urandom_range(5, 30)) member_buf.push_back(rand_byte(0, 255));
			end else if (k < 93) begin
				member_buf.delete();
				repeat ($urandom_range(1, 17)) member_buf.push_back(rand_byte(0, 255));
			end else begin
				member_buf.delete();
				repeat ($urandom_range(1, 30)) member_buf.push_back(rand_byte(0, 255));
			end
			plan_member(members_planned_hold(byte_plan.size()));
		end
		item_total = byte_plan.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_plan.size() != 0 || s_axis_tvalid || expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TICKS) @(posedge clk);

		$display("deframed %0d members from %0d bytes, %0d payload bytes passed",
			members_done, accepted, payload_out);
		$display("reports: ok %0d, short %0d, bad magic/method %0d, truncated %0d, empty %0d",
			status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_BAD_MAGIC],
			status_seen[ST_TRUNC], status_seen[ST_EMPTY]);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
